FILE: rtl/core/sed_pkg.sv
// Package for the STX/ETX escaped deframer.
// Holds the result kind codes, the register indexes and the frame size limit.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package sed_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 13;
	localparam int unsigned KindW  = 3;
	localparam int unsigned CfgIdxW = 2;

	// Largest number of payload bytes that one frame may carry.
	localparam logic [LenW-1:0] MaxPayload = 13'd4096;

	// Reset values of the delimiter registers.
	localparam logic [ByteW-1:0] StartReset  = 8'h02;
	localparam logic [ByteW-1:0] EndReset    = 8'h03;
	localparam logic [ByteW-1:0] EscapeReset = 8'h10;

	// Code carried in the kind field of a result beat.
	typedef enum logic [KindW-1:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_END      = 3'd1,
		KIND_ABORT    = 3'd2,
		KIND_ESC_ERR  = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_START  = 2'd0,
		REG_END    = 2'd1,
		REG_ESCAPE = 2'd2
	} cfg_idx_t;

	// One result beat as held in the output register.
	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		kind_t            kind;
		logic [LenW-1:0]  frame_length;
	} result_t;

endpackage

FILE: rtl/core/sed_if.sv
// Valid/ready channel interfaces of the deframer: received bytes in, results out.
// Depends on sed_pkg for the field widths.
`timescale 1ns / 1ps

interface sed_in_if
	import sed_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sed_out_if
	import sed_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] payload_byte;
	logic [KindW-1:0] kind;
	logic [LenW-1:0]  frame_length;

	modport source (output valid, output payload_byte, output kind, output frame_length,
		input ready);
	modport sink   (input valid, input payload_byte, input kind, input frame_length,
		output ready);
endinterface

FILE: rtl/core/stx_etx_escaped_deframer.sv
// STX/ETX byte-stuffing deframer with escape handling, size limit and error reporting.
// Depends on sed_pkg and the channel interfaces in sed_if.sv.
//
// The deframer takes one received byte per beat on rx and gives at most one result beat
// on res per byte. While hunting it drops bytes until the start byte. Inside a frame a
// start byte aborts (kind 2), the end byte closes the frame (kind 1, or kind 3 when it
// follows a dangling escape), the escape byte makes the next byte come out complemented,
// and other bytes come out as payload (kind 0) with the running length. A payload byte
// beyond the frame limit aborts the frame as overflow (kind 4). The block accepts one
// byte every cycle unless the output register stalls: a byte passes an input register,
// the compare logic and an output register, which presents its result beat.
// Only a stalled output register holds up the input. The delimiter registers must be
// written while no byte is in flight.
`timescale 1ns / 1ps

module stx_etx_escaped_deframer
	import sed_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [ByteW-1:0]    cfg_data,
	sed_in_if.sink              rx,
	sed_out_if.source           res
);

	logic [ByteW-1:0] start_byte_q;
	logic [ByteW-1:0] end_byte_q;
	logic [ByteW-1:0] escape_byte_q;

	logic             in_frame_q;
	logic             escape_pending_q;
	logic [LenW-1:0]  payload_count_q;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	logic             out_valid_q;
	result_t          out_q;

	logic             advance;
	logic             has_result;
	result_t          result;
	logic             in_frame_d;
	logic             escape_pending_d;
	logic [LenW-1:0]  payload_count_d;
	logic [LenW-1:0]  count_inc;
	logic [ByteW-1:0] data_byte;

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= StartReset;
			end_byte_q    <= EndReset;
			escape_byte_q <= EscapeReset;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_START:  start_byte_q  <= cfg_data;
				REG_END:    end_byte_q    <= cfg_data;
				REG_ESCAPE: escape_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held byte moves on when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign count_inc = payload_count_q + LenW'(1);
	assign data_byte = escape_pending_q ? ~byte_s1 : byte_s1;

	// Byte classification and frame state update; start wins over end, end over escape.
	always_comb begin
		has_result          = 1'b0;
		result.payload_byte = '0;
		result.kind         = KIND_PAYLOAD;
		result.frame_length = payload_count_q;
		in_frame_d          = in_frame_q;
		escape_pending_d    = escape_pending_q;
		payload_count_d     = payload_count_q;

		if (!in_frame_q) begin
			if (byte_s1 == start_byte_q) begin
				in_frame_d       = 1'b1;
				escape_pending_d = 1'b0;
				payload_count_d  = '0;
			end
		end else if (byte_s1 == start_byte_q) begin
			has_result  = 1'b1;
			result.kind = KIND_ABORT;
			in_frame_d       = 1'b0;
			escape_pending_d = 1'b0;
			payload_count_d  = '0;
		end else if (byte_s1 == end_byte_q) begin
			has_result  = 1'b1;
			result.kind = escape_pending_q ? KIND_ESC_ERR : KIND_END;
			in_frame_d       = 1'b0;
			escape_pending_d = 1'b0;
			payload_count_d  = '0;
		end else if (!escape_pending_q && byte_s1 == escape_byte_q) begin
			escape_pending_d = 1'b1;
		end else if (payload_count_q >= MaxPayload) begin
			has_result  = 1'b1;
			result.kind = KIND_OVERFLOW;
			in_frame_d       = 1'b0;
			escape_pending_d = 1'b0;
			payload_count_d  = '0;
		end else begin
			has_result          = 1'b1;
			result.payload_byte = data_byte;
			result.frame_length = count_inc;
			escape_pending_d    = 1'b0;
			payload_count_d     = count_inc;
		end
	end

	// Frame state advances once per byte that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q       <= 1'b0;
			escape_pending_q <= 1'b0;
			payload_count_q  <= '0;
		end else if (advance) begin
			in_frame_q       <= in_frame_d;
			escape_pending_q <= escape_pending_d;
			payload_count_q  <= payload_count_d;
		end
	end

	// Output register; a beat stays until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.payload_byte = out_q.payload_byte;
	assign res.kind         = KindW'(out_q.kind);
	assign res.frame_length = out_q.frame_length;

endmodule
